// ===== hw/rtl/coapmp_pkg.sv =====
// Package for the CoAP message parser: phase, kind and status codes,
// state and result structs, and the option length table.
// Used by coapmp_step and coap_message_parser.
package coapmp_pkg;

    localparam logic [3:0] MAX_TOKEN_BYTES = 4'd8;

    localparam logic [2:0] PH_HDR       = 3'd0;
    localparam logic [2:0] PH_TOKEN     = 3'd1;
    localparam logic [2:0] PH_OPT_HEAD  = 3'd2;
    localparam logic [2:0] PH_DELTA_EXT = 3'd3;
    localparam logic [2:0] PH_LEN_EXT   = 3'd4;
    localparam logic [2:0] PH_OPT_VALUE = 3'd5;
    localparam logic [2:0] PH_PAYLOAD   = 3'd6;
    localparam logic [2:0] PH_DISCARD   = 3'd7;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_TOKEN   = 3'd1;
    localparam logic [2:0] KIND_OPT_HD  = 3'd2;
    localparam logic [2:0] KIND_OPT_VAL = 3'd3;
    localparam logic [2:0] KIND_MARKER  = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_DISCARD = 3'd6;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FORMAT   = 2'd1;
    localparam logic [1:0] STAT_CRIT_OPT = 2'd2;

    localparam logic [1:0] COAP_VERSION = 2'd1;
    localparam logic [7:0] PAYLOAD_MARKER = 8'hff;
    localparam logic [3:0] NIB_EXT8   = 4'd13;
    localparam logic [3:0] NIB_RSVD   = 4'd15;
    localparam logic [16:0] EXT8_BASE  = 17'd13;
    localparam logic [16:0] EXT16_BASE = 17'd269;
    localparam logic [16:0] MAX_FIELD  = 17'd65535;

    localparam logic [15:0] OPT_IF_MATCH       = 16'd1;
    localparam logic [15:0] OPT_URI_HOST       = 16'd3;
    localparam logic [15:0] OPT_ETAG           = 16'd4;
    localparam logic [15:0] OPT_IF_NONE_MATCH  = 16'd5;
    localparam logic [15:0] OPT_URI_PORT       = 16'd7;
    localparam logic [15:0] OPT_LOCATION_PATH  = 16'd8;
    localparam logic [15:0] OPT_URI_PATH       = 16'd11;
    localparam logic [15:0] OPT_CONTENT_FORMAT = 16'd12;
    localparam logic [15:0] OPT_MAX_AGE        = 16'd14;
    localparam logic [15:0] OPT_URI_QUERY      = 16'd15;
    localparam logic [15:0] OPT_ACCEPT         = 16'd17;
    localparam logic [15:0] OPT_LOCATION_QUERY = 16'd20;
    localparam logic [15:0] OPT_PROXY_URI      = 16'd35;
    localparam logic [15:0] OPT_PROXY_SCHEME   = 16'd39;
    localparam logic [15:0] OPT_SIZE1          = 16'd60;

    localparam logic [16:0] LEN_PROXY_URI_MAX = 17'd1034;
    localparam logic [16:0] LEN_STRING_MAX    = 17'd255;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  pbc;
        logic [1:0]  hdr_type;
        logic [7:0]  hdr_code;
        logic [15:0] hdr_msg_id;
        logic [3:0]  hdr_token_len;
        logic [15:0] prev_opt_num;
        logic [16:0] delta_acc;
        logic [16:0] len_acc;
        logic [15:0] bytes_rem;
        logic [1:0]  err;
        logic        opt_ign;
    } st_t;

    localparam st_t ST_RESET = '{
        phase: PH_HDR, pbc: 2'd0, hdr_type: 2'd0, hdr_code: 8'd0, hdr_msg_id: 16'd0,
        hdr_token_len: 4'd0, prev_opt_num: 16'd0, delta_acc: 17'd0, len_acc: 17'd0,
        bytes_rem: 16'd0, err: STAT_OK, opt_ign: 1'b0
    };

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] message_id;
        logic [3:0]  token_len;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic        option_ignored;
        logic        message_done;
        logic [1:0]  status;
    } res_t;

    function automatic logic opt_valid(input logic [15:0] num, input logic [16:0] len);
        logic ok;
        case (num)
            OPT_IF_MATCH:       ok = (len <= 17'd8);
            OPT_URI_HOST:       ok = (len >= 17'd1) && (len <= LEN_STRING_MAX);
            OPT_ETAG:           ok = (len >= 17'd1) && (len <= 17'd8);
            OPT_IF_NONE_MATCH:  ok = (len == 17'd0);
            OPT_URI_PORT:       ok = (len <= 17'd2);
            OPT_LOCATION_PATH:  ok = (len <= LEN_STRING_MAX);
            OPT_URI_PATH:       ok = (len <= LEN_STRING_MAX);
            OPT_CONTENT_FORMAT: ok = (len <= 17'd2);
            OPT_MAX_AGE:        ok = (len <= 17'd4);
            OPT_URI_QUERY:      ok = (len <= LEN_STRING_MAX);
            OPT_ACCEPT:         ok = (len <= 17'd2);
            OPT_LOCATION_QUERY: ok = (len <= LEN_STRING_MAX);
            OPT_PROXY_URI:      ok = (len >= 17'd1) && (len <= LEN_PROXY_URI_MAX);
            OPT_PROXY_SCHEME:   ok = (len >= 17'd1) && (len <= LEN_STRING_MAX);
            OPT_SIZE1:          ok = (len <= 17'd4);
            default:            ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic opt_critical(input logic [15:0] num);
        logic crit;
        case (num) inside
            OPT_IF_MATCH, OPT_URI_HOST, OPT_IF_NONE_MATCH, OPT_URI_PORT, OPT_URI_PATH,
            OPT_URI_QUERY, OPT_ACCEPT, OPT_PROXY_URI, OPT_PROXY_SCHEME: crit = 1'b1;
            default: crit = 1'b0;
        endcase
        return crit;
    endfunction

endpackage

// ===== hw/rtl/coapmp_step.sv =====
// Per-byte parse step: next parser state and the result for one byte.
// Purely combinational; depends on coapmp_pkg.
module coapmp_step #(
    parameter logic [3:0] TOKEN_MAX = coapmp_pkg::MAX_TOKEN_BYTES
) (
    input  coapmp_pkg::st_t  cur,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output coapmp_pkg::st_t  nxt,
    output coapmp_pkg::res_t res
);
    import coapmp_pkg::*;

    logic [2:0]  kind;
    logic        show;
    logic        go_ad;
    logic        go_hc;
    logic [17:0] sum;
    logic [15:0] rem_dec;
    logic        sum_ok;
    logic        sum_valid;
    logic        sum_crit;
    logic        fin_valid;
    logic        fin_crit;

    assign rem_dec   = (cur.bytes_rem != 16'd0) ? cur.bytes_rem - 16'd1 : 16'd0;
    assign fin_valid = opt_valid(cur.prev_opt_num, cur.len_acc);
    assign fin_crit  = opt_critical(cur.prev_opt_num);

    always_comb begin
        nxt   = cur;
        kind  = KIND_DISCARD;
        show  = 1'b0;
        go_ad = 1'b0;
        go_hc = 1'b0;
        unique case (cur.phase)
            PH_HDR: begin
                kind = KIND_HEADER;
                unique case (cur.pbc)
                    2'd0: begin
                        nxt.hdr_type      = data_byte[5:4];
                        nxt.hdr_token_len = data_byte[3:0];
                        if (data_byte[7:6] != COAP_VERSION || data_byte[3:0] > TOKEN_MAX) begin
                            nxt.err   = STAT_FORMAT;
                            nxt.phase = PH_DISCARD;
                        end else begin
                            nxt.pbc = 2'd1;
                        end
                    end
                    2'd1: begin
                        nxt.hdr_code = data_byte;
                        nxt.pbc      = 2'd2;
                    end
                    2'd2: begin
                        nxt.bytes_rem = {8'd0, data_byte};
                        nxt.pbc       = 2'd3;
                    end
                    default: begin
                        nxt.hdr_msg_id = {cur.bytes_rem[7:0], data_byte};
                        nxt.bytes_rem  = {12'd0, cur.hdr_token_len};
                        nxt.pbc        = 2'd0;
                        nxt.phase      = (cur.hdr_token_len != 4'd0) ? PH_TOKEN : PH_OPT_HEAD;
                    end
                endcase
            end
            PH_TOKEN: begin
                kind          = KIND_TOKEN;
                nxt.bytes_rem = rem_dec;
                if (rem_dec == 16'd0) begin
                    nxt.phase = PH_OPT_HEAD;
                end
            end
            PH_OPT_HEAD: begin
                if (data_byte == PAYLOAD_MARKER) begin
                    kind = KIND_MARKER;
                    if (last_byte) begin
                        nxt.err   = STAT_FORMAT;
                        nxt.phase = PH_DISCARD;
                    end else begin
                        nxt.phase = PH_PAYLOAD;
                    end
                end else begin
                    kind = KIND_OPT_HD;
                    if (data_byte[7:4] == NIB_RSVD || data_byte[3:0] == NIB_RSVD) begin
                        nxt.err   = STAT_FORMAT;
                        nxt.phase = PH_DISCARD;
                    end else begin
                        nxt.delta_acc = {13'd0, data_byte[7:4]};
                        nxt.len_acc   = {13'd0, data_byte[3:0]};
                        nxt.pbc       = 2'd0;
                        if (data_byte[7:4] >= NIB_EXT8) begin
                            nxt.phase = PH_DELTA_EXT;
                        end else begin
                            go_ad = 1'b1;
                        end
                    end
                end
            end
            PH_DELTA_EXT: begin
                kind = KIND_OPT_HD;
                if (cur.pbc == 2'd0 && cur.delta_acc == EXT8_BASE) begin
                    nxt.delta_acc = EXT8_BASE + {9'd0, data_byte};
                    go_ad         = 1'b1;
                end else if (cur.pbc == 2'd0) begin
                    nxt.bytes_rem = {8'd0, data_byte};
                    nxt.pbc       = 2'd1;
                end else begin
                    nxt.delta_acc = EXT16_BASE + {1'b0, cur.bytes_rem[7:0], data_byte};
                    go_ad         = 1'b1;
                end
            end
            PH_LEN_EXT: begin
                kind = KIND_OPT_HD;
                if (cur.pbc == 2'd0 && cur.len_acc == EXT8_BASE) begin
                    nxt.len_acc = EXT8_BASE + {9'd0, data_byte};
                    go_hc       = 1'b1;
                end else if (cur.pbc == 2'd0) begin
                    nxt.bytes_rem = {8'd0, data_byte};
                    nxt.pbc       = 2'd1;
                end else begin
                    nxt.len_acc = EXT16_BASE + {1'b0, cur.bytes_rem[7:0], data_byte};
                    go_hc       = 1'b1;
                end
            end
            PH_OPT_VALUE: begin
                kind          = KIND_OPT_VAL;
                show          = 1'b1;
                nxt.bytes_rem = rem_dec;
                if (rem_dec == 16'd0) begin
                    nxt.phase = PH_OPT_HEAD;
                    if (!fin_valid && fin_crit) begin
                        nxt.err   = STAT_CRIT_OPT;
                        nxt.phase = PH_DISCARD;
                    end
                end
            end
            PH_PAYLOAD: begin
                kind = KIND_PAYLOAD;
            end
            default: begin
                kind = KIND_DISCARD;
            end
        endcase

        if (go_ad) begin
            if (nxt.len_acc >= {13'd0, NIB_EXT8}) begin
                nxt.phase = PH_LEN_EXT;
                nxt.pbc   = 2'd0;
            end else begin
                go_hc = 1'b1;
            end
        end

        sum       = {2'd0, cur.prev_opt_num} + {1'b0, nxt.delta_acc};
        sum_ok    = (nxt.delta_acc <= MAX_FIELD) && (nxt.len_acc <= MAX_FIELD)
                    && (sum <= {1'b0, MAX_FIELD});
        sum_valid = opt_valid(sum[15:0], nxt.len_acc);
        sum_crit  = opt_critical(sum[15:0]);

        if (go_hc) begin
            if (!sum_ok) begin
                nxt.err   = STAT_FORMAT;
                nxt.phase = PH_DISCARD;
            end else begin
                show             = 1'b1;
                nxt.prev_opt_num = sum[15:0];
                nxt.opt_ign      = !sum_valid && !sum_crit;
                if (nxt.len_acc == 17'd0) begin
                    nxt.phase = PH_OPT_HEAD;
                    if (!sum_valid && sum_crit) begin
                        nxt.err   = STAT_CRIT_OPT;
                        nxt.phase = PH_DISCARD;
                    end
                end else begin
                    nxt.phase     = PH_OPT_VALUE;
                    nxt.bytes_rem = nxt.len_acc[15:0];
                end
            end
        end

        if (last_byte && nxt.err == STAT_OK &&
            (nxt.phase == PH_HDR || nxt.phase == PH_TOKEN || nxt.phase == PH_DELTA_EXT ||
             nxt.phase == PH_LEN_EXT || nxt.phase == PH_OPT_VALUE)) begin
            nxt.err   = STAT_FORMAT;
            nxt.phase = PH_DISCARD;
        end

        res.byte_kind      = kind;
        res.msg_type       = nxt.hdr_type;
        res.msg_code       = nxt.hdr_code;
        res.message_id     = nxt.hdr_msg_id;
        res.token_len      = nxt.hdr_token_len;
        res.option_number  = show ? nxt.prev_opt_num : 16'd0;
        res.option_length  = show ? nxt.len_acc[15:0] : 16'd0;
        res.option_ignored = show ? nxt.opt_ign : 1'b0;
        res.message_done   = last_byte;
        res.status         = nxt.err;

        if (last_byte) begin
            nxt = ST_RESET;
        end
    end

endmodule

// ===== hw/rtl/coap_message_parser.sv =====
// CoAP message parser top level: parser state, result register, stream handshake.
// Depends on coapmp_pkg and coapmp_step.
//
//  channel  | dir | tdata                    | tlast        | tuser
//  s_       | in  | [7:0] data_byte          | last_byte    | -
//  m_       | out | header/option/status     | message_done | [2:0] byte_kind
//
// One byte per cycle unless the result stalls: each transfer updates the parser
// state and loads the result register in the same cycle; a result appears in the
// cycle after its byte. aresetn (synchronous) returns the parser to the first
// header byte and empties the result register. A stalled result holds; s_tready
// stays high while the result register is empty or is being drained in that cycle.
module coap_message_parser #(
    parameter logic [3:0] TOKEN_MAX = coapmp_pkg::MAX_TOKEN_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [1:0] msg_type, [9:2] msg_code, [25:10] message_id,
                                   // [29:26] token_len, [45:30] option_number,
                                   // [61:46] option_length, [62] option_ignored,
                                   // [64:63] status, [71:65] zero
    output logic [2:0]  m_tuser,   // [2:0] byte_kind
    output logic        m_tlast
);
    import coapmp_pkg::*;

    st_t  st_reg;
    st_t  st_next;
    res_t res_reg;
    res_t res_next;
    logic m_valid_reg;
    logic s_xfer;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    coapmp_step #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_step (
        .cur       (st_reg),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .nxt       (st_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                st_reg <= st_next;
            end
            if (s_tready) begin
                m_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.byte_kind;
    assign m_tlast  = res_reg.message_done;
    assign m_tdata  = {7'd0, res_reg.status, res_reg.option_ignored, res_reg.option_length,
                       res_reg.option_number, res_reg.token_len, res_reg.message_id,
                       res_reg.msg_code, res_reg.msg_type};

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tlast) |=> (st_reg.phase == PH_HDR && st_reg.err == STAT_OK))
        else $error("parser state not cleared after last byte");

    a_err_discards: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.err != STAT_OK) |-> (st_reg.phase == PH_DISCARD))
        else $error("error recorded outside discard phase");

    a_discard_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.byte_kind == KIND_DISCARD) |-> (res_reg.status != STAT_OK))
        else $error("discarded byte reported with ok status");

    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_xfer && $past(aresetn)) |=> $stable(st_reg))
        else $error("parser state moved without a transfer");

endmodule
